// File: rtl/esc_pkg.sv
// ----------------------------------------------------------------------------
// esc_pkg
// Constants and tables for the seconds-to-calendar pipeline: reciprocal
// multipliers for the constant divisions and the month start table.
// ----------------------------------------------------------------------------
package esc_pkg;

  localparam int unsigned NumStages = 6;

  // Division constants
  localparam logic [16:0] SecsPerDay  = 17'd86400;
  localparam logic [11:0] SecsPerHour = 12'd3600;
  localparam logic [5:0]  SecsPerMin  = 6'd60;
  localparam logic [10:0] DaysPerQuad = 11'd1461;
  localparam logic [8:0]  DaysPerYear = 9'd365;
  localparam logic [2:0]  DaysPerWeek = 3'd7;

  // Day 0 is a Thursday; the four-year cycle is counted from 1969-01-01,
  // so its leap year is the last of the four.
  localparam logic [2:0]  EpochWeekday = 3'd4;
  localparam logic [7:0]  QuadBaseYear = 8'd69;

  // Reciprocals, rounded up: floor(x * M >> K) is exact over each input range
  localparam logic [31:0] MulDay  = 32'd3257812231;  // 1/86400, K = 48, x < 2^31
  localparam logic [17:0] MulHour = 18'd149131;      // 1/3600,  K = 29, x < 2^17
  localparam logic [12:0] MulMin  = 13'd4370;        // 1/60,    K = 18, x < 2^12
  localparam logic [15:0] MulQuad = 16'd45934;       // 1/1461,  K = 26, x < 2^15
  localparam logic [15:0] MulWeek = 16'd37450;       // 1/7,     K = 18, x < 2^15

  // First day of year of each month, January is 0
  function automatic logic [8:0] month_start(input logic leap, input logic [3:0] mon);
    logic [8:0] d;
    unique case (mon)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = leap ? 9'd60  : 9'd59;
      4'd3:    d = leap ? 9'd91  : 9'd90;
      4'd4:    d = leap ? 9'd121 : 9'd120;
      4'd5:    d = leap ? 9'd152 : 9'd151;
      4'd6:    d = leap ? 9'd182 : 9'd181;
      4'd7:    d = leap ? 9'd213 : 9'd212;
      4'd8:    d = leap ? 9'd244 : 9'd243;
      4'd9:    d = leap ? 9'd274 : 9'd273;
      4'd10:   d = leap ? 9'd305 : 9'd304;
      4'd11:   d = leap ? 9'd335 : 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

// File: rtl/epoch_seconds_to_calendar_unit.sv
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_unit
// Converts a 32-bit seconds count since 1970-01-01 into the broken-down UTC
// date through a six-stage pipeline of reciprocal multiplies.
// ----------------------------------------------------------------------------
//  channel  | handshake         | payload
//  ---------+-------------------+-------------------------------------------
//  command  | start_i / busy_o  | timestamp_i
//  result   | done_o (strobe)   | valid_res_o, second_o .. day_of_year_o
//
//  One timestamp per cycle is taken; busy_o stays low.
//  Each result is registered once in every stage after its transfer.
//  Stage depth is set by one constant multiply each, with a subtract or compare behind it in some.
//  Reset clears the stage valid bits; payload registers are not reset.
//  The receiver cannot stall, so nothing is held back inside the pipeline.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [31:0] timestamp_i,
  output logic        done_o,
  output logic        valid_res_o,
  output logic [5:0]  second_o,
  output logic [5:0]  minute_o,
  output logic [4:0]  hour_o,
  output logic [4:0]  day_of_month_o,
  output logic [3:0]  month_o,
  output logic [7:0]  years_since_1900_o,
  output logic [2:0]  weekday_o,
  output logic [8:0]  day_of_year_o
);
  import esc_pkg::*;

  logic                 accept;
  logic [NumStages-1:0] vld_q;
  logic [NumStages-1:0] bad_q;

  // Stage 1: whole days by reciprocal
  logic [62:0] day_prod;
  logic [14:0] s1_days_q;
  logic [16:0] s1_tlo_q;

  // Stage 2: seconds of day, offset day counts
  logic [31:0] day_secs;
  logic [16:0] s2_sod_q;
  logic [14:0] s2_dq_q;
  logic [14:0] s2_dw_q;

  // Stage 3: hour, four-year cycle, week count
  logic [34:0] hour_prod;
  logic [30:0] quad_prod;
  logic [30:0] week_prod;
  logic [16:0] s3_sod_q;
  logic [14:0] s3_dq_q;
  logic [14:0] s3_dw_q;
  logic [4:0]  s3_hour_q;
  logic [4:0]  s3_quad_q;
  logic [11:0] s3_week_q;

  // Stage 4: remainders
  logic [16:0] hour_secs;
  logic [14:0] quad_days;
  logic [14:0] week_days;
  logic [11:0] s4_soh_q;
  logic [10:0] s4_doq_q;
  logic [2:0]  s4_wday_q;
  logic [4:0]  s4_hour_q;
  logic [4:0]  s4_quad_q;

  // Stage 5: minute, year within cycle, day of year
  logic [24:0] min_prod;
  logic [1:0]  yi;
  logic [8:0]  yday;
  logic [11:0] s5_soh_q;
  logic [5:0]  s5_min_q;
  logic [1:0]  s5_yi_q;
  logic [8:0]  s5_yday_q;
  logic [2:0]  s5_wday_q;
  logic [4:0]  s5_hour_q;
  logic [4:0]  s5_quad_q;

  // Stage 6: output
  logic        leap;
  logic [3:0]  mon;
  logic [8:0]  mstart;
  logic [11:0] min_secs;
  logic [5:0]  second_q;
  logic [5:0]  minute_q;
  logic [4:0]  hour_q;
  logic [4:0]  mday_q;
  logic [3:0]  month_q;
  logic [7:0]  year_q;
  logic [2:0]  wday_q;
  logic [8:0]  yday_q;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  always_comb begin
    day_prod  = 63'(timestamp_i[30:0]) * 63'(MulDay);
    day_secs  = 32'(s1_days_q) * 32'(SecsPerDay);
    hour_prod = 35'(s2_sod_q) * 35'(MulHour);
    quad_prod = 31'(s2_dq_q) * 31'(MulQuad);
    week_prod = 31'(s2_dw_q) * 31'(MulWeek);
    hour_secs = 17'(s3_hour_q) * 17'(SecsPerHour);
    quad_days = 15'(s3_quad_q) * 15'(DaysPerQuad);
    week_days = 15'(s3_week_q) * 15'(DaysPerWeek);
    min_prod  = 25'(s4_soh_q) * 25'(MulMin);
    min_secs  = 12'(s5_min_q) * 12'(SecsPerMin);
  end

  // Year within the four-year cycle; the last one takes the 366th day
  always_comb begin
    if (s4_doq_q >= 11'(3 * DaysPerYear)) begin
      yi = 2'd3;
    end else if (s4_doq_q >= 11'(2 * DaysPerYear)) begin
      yi = 2'd2;
    end else if (s4_doq_q >= 11'(DaysPerYear)) begin
      yi = 2'd1;
    end else begin
      yi = 2'd0;
    end
    yday = 9'(s4_doq_q - 11'(yi) * 11'(DaysPerYear));
  end

  // Month search: starts rise monotonically, so the last match wins
  always_comb begin
    leap = (s5_yi_q == 2'd3);
    mon  = 4'd0;
    for (int i = 1; i < 12; i++) begin
      if (s5_yday_q >= month_start(leap, 4'(i))) begin
        mon = 4'(i);
      end
    end
    mstart = month_start(leap, mon);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[NumStages-2:0], accept};
    end
  end

  always_ff @(posedge clk_i) begin
    bad_q <= {bad_q[NumStages-2:0], timestamp_i[31]};

    s1_days_q <= day_prod[62:48];
    s1_tlo_q  <= timestamp_i[16:0];

    s2_sod_q <= s1_tlo_q - day_secs[16:0];
    s2_dq_q  <= s1_days_q + 15'(DaysPerYear);
    s2_dw_q  <= s1_days_q + 15'(EpochWeekday);

    s3_sod_q  <= s2_sod_q;
    s3_dq_q   <= s2_dq_q;
    s3_dw_q   <= s2_dw_q;
    s3_hour_q <= hour_prod[33:29];
    s3_quad_q <= quad_prod[30:26];
    s3_week_q <= week_prod[29:18];

    s4_soh_q  <= 12'(s3_sod_q - hour_secs);
    s4_doq_q  <= 11'(s3_dq_q - quad_days);
    s4_wday_q <= 3'(s3_dw_q - week_days);
    s4_hour_q <= s3_hour_q;
    s4_quad_q <= s3_quad_q;

    s5_soh_q  <= s4_soh_q;
    s5_min_q  <= min_prod[23:18];
    s5_yi_q   <= yi;
    s5_yday_q <= yday;
    s5_wday_q <= s4_wday_q;
    s5_hour_q <= s4_hour_q;
    s5_quad_q <= s4_quad_q;

    // Drop everything to zero for an out-of-range timestamp
    if (bad_q[NumStages-2]) begin
      second_q <= '0;
      minute_q <= '0;
      hour_q   <= '0;
      mday_q   <= '0;
      month_q  <= '0;
      year_q   <= '0;
      wday_q   <= '0;
      yday_q   <= '0;
    end else begin
      second_q <= 6'(s5_soh_q - min_secs);
      minute_q <= s5_min_q;
      hour_q   <= s5_hour_q;
      mday_q   <= 5'(s5_yday_q - mstart + 9'd1);
      month_q  <= mon;
      year_q   <= QuadBaseYear + 8'({s5_quad_q, 2'b00}) + 8'(s5_yi_q);
      wday_q   <= s5_wday_q;
      yday_q   <= s5_yday_q;
    end
  end

  assign done_o             = vld_q[NumStages-1];
  assign valid_res_o        = !bad_q[NumStages-1];
  assign second_o           = second_q;
  assign minute_o           = minute_q;
  assign hour_o             = hour_q;
  assign day_of_month_o     = mday_q;
  assign month_o            = month_q;
  assign years_since_1900_o = year_q;
  assign weekday_o          = wday_q;
  assign day_of_year_o      = yday_q;

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##6 done_o)
    else $error("result strobe missing six cycles after transfer");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !valid_res_o |-> second_o == '0 && minute_o == '0 && hour_o == '0 &&
      day_of_month_o == '0 && month_o == '0 && years_since_1900_o == '0 &&
      weekday_o == '0 && day_of_year_o == '0)
    else $error("invalid result carries nonzero fields");

  a_date_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && valid_res_o |-> day_of_month_o != '0 && month_o <= 4'd11 &&
      years_since_1900_o >= 8'd70 && years_since_1900_o <= 8'd138)
    else $error("calendar date out of range");

  a_time_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && valid_res_o |-> second_o < 6'd60 && minute_o < 6'd60 &&
      hour_o < 5'd24 && weekday_o < 3'd7)
    else $error("time of day or weekday out of range");

endmodule
